>>> sv/cle_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the cursor line edit buffer.
package cle_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] LEFT_CODE_RST  = 8'd60;  // '<'
   localparam logic [7:0] RIGHT_CODE_RST = 8'd62;  // '>'
   localparam logic [7:0] ERASE_CODE_RST = 8'd45;  // '-'

   typedef enum logic [1:0] {
      REG_LEFT_CODE  = 2'd0,
      REG_RIGHT_CODE = 2'd1,
      REG_ERASE_CODE = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic       func;
      logic [7:0] key;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_last;
      logic       line_empty;
   } rsp_type;

   typedef struct packed {
      logic [7:0] left_code;
      logic [7:0] right_code;
      logic [7:0] erase_code;
   } cfg_type;

   typedef enum logic [1:0] {
      KEY_LEFT,
      KEY_RIGHT,
      KEY_ERASE,
      KEY_CHAR
   } key_cls_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INSERT,
      OP_ERASE,
      OP_MVL_RD,
      OP_MVL_WR,
      OP_MVR_RD,
      OP_MVR_WR,
      OP_FL_RD,
      OP_FL_LOAD,
      OP_FL_EMPTY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      key_cls_type key_cls;
      logic        empty;
      logic        can_insert;
      logic        can_erase;
      logic        can_left;
      logic        can_right;
      logic        last;
   } sts_type;

endpackage

>>> sv/cle_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cle_csr.sv
`timescale 1ns / 1ps
// APB register block holding the three editing key codes.
module cle_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output cle_pkg::cfg_type                 cfg
);
   import cle_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx   = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_LEFT_CODE:  cfg_in.left_code  = csr_pwdata[7:0];
            REG_RIGHT_CODE: cfg_in.right_code = csr_pwdata[7:0];
            REG_ERASE_CODE: cfg_in.erase_code = csr_pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_code  <= LEFT_CODE_RST;
         cfg_ff.right_code <= RIGHT_CODE_RST;
         cfg_ff.erase_code <= ERASE_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_LEFT_CODE:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.left_code};
         REG_RIGHT_CODE: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.right_code};
         REG_ERASE_CODE: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.erase_code};
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

>>> sv/cle_datapath.sv
`timescale 1ns / 1ps
// Gap buffer datapath: the two character stacks, their counts and the result register.
module cle_datapath (
   input  logic             clock,
   input  logic             reset,
   input  cle_pkg::req_type req_data,
   input  cle_pkg::cfg_type cfg,
   input  cle_pkg::cmd_type cmd,
   output cle_pkg::sts_type sts,
   output cle_pkg::rsp_type rsp_data
);
   import cle_pkg::*;

   logic [CNT_W-1:0]  lc_ff, lc_in;
   logic [CNT_W-1:0]  rc_ff, rc_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              src_left_ff, src_left_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  lc_dec;
   logic [CNT_W-1:0]  rc_dec;
   logic [CNT_W-1:0]  total_dec;
   logic [CNT_W-1:0]  rev_pos;

   logic              l_we, r_we;
   logic [ADDR_W-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
   logic [7:0]        l_wdata, r_wdata, l_rdata, r_rdata;

   assign total     = lc_ff + rc_ff;
   assign lc_dec    = lc_ff - CNT_W'(1);
   assign rc_dec    = rc_ff - CNT_W'(1);
   assign total_dec = total - CNT_W'(1);
   // right stack is walked from its top down: position pos maps to total-1-pos
   assign rev_pos   = total_dec - pos_ff;

   always_comb begin
      priority if (req_data.key == cfg.left_code) begin
         sts.key_cls = KEY_LEFT;
      end else if (req_data.key == cfg.right_code) begin
         sts.key_cls = KEY_RIGHT;
      end else if (req_data.key == cfg.erase_code) begin
         sts.key_cls = KEY_ERASE;
      end else begin
         sts.key_cls = KEY_CHAR;
      end
      sts.empty      = (total == '0);
      sts.can_insert = (total < CNT_W'(LINE_DEPTH));
      sts.can_erase  = (lc_ff != '0);
      sts.can_left   = (lc_ff != '0) && (rc_ff < CNT_W'(LINE_DEPTH));
      sts.can_right  = (rc_ff != '0) && (lc_ff < CNT_W'(LINE_DEPTH));
      sts.last       = rsp_ff.is_last;
   end

   assign l_we    = (cmd.op == OP_INSERT) || (cmd.op == OP_MVR_WR);
   assign l_waddr = lc_ff[ADDR_W-1:0];
   assign l_wdata = (cmd.op == OP_INSERT) ? req_data.key : r_rdata;
   assign l_raddr = (cmd.op == OP_MVL_RD) ? lc_dec[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];

   assign r_we    = (cmd.op == OP_MVL_WR);
   assign r_waddr = rc_ff[ADDR_W-1:0];
   assign r_wdata = l_rdata;
   assign r_raddr = (cmd.op == OP_MVR_RD) ? rc_dec[ADDR_W-1:0] : rev_pos[ADDR_W-1:0];

   cle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_left_stack (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   cle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_right_stack (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   always_comb begin
      lc_in       = lc_ff;
      rc_in       = rc_ff;
      pos_in      = pos_ff;
      src_left_in = src_left_ff;
      rsp_in      = rsp_ff;
      unique case (cmd.op)
         OP_INSERT: lc_in = lc_ff + CNT_W'(1);
         OP_ERASE:  lc_in = lc_dec;
         OP_MVL_RD: lc_in = lc_dec;
         OP_MVL_WR: rc_in = rc_ff + CNT_W'(1);
         OP_MVR_RD: rc_in = rc_dec;
         OP_MVR_WR: lc_in = lc_ff + CNT_W'(1);
         OP_FL_RD:  src_left_in = (pos_ff < lc_ff);
         OP_FL_LOAD: begin
            rsp_in.out_char   = src_left_ff ? l_rdata : r_rdata;
            rsp_in.is_last    = (pos_ff == total_dec);
            rsp_in.line_empty = 1'b0;
            pos_in            = pos_ff + CNT_W'(1);
         end
         OP_FL_EMPTY: begin
            rsp_in.out_char   = 8'd0;
            rsp_in.is_last    = 1'b1;
            rsp_in.line_empty = 1'b1;
         end
         OP_CLEAR: begin
            lc_in  = '0;
            rc_in  = '0;
            pos_in = '0;
         end
         default: lc_in = lc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff  <= '0;
         rc_ff  <= '0;
         pos_ff <= '0;
      end else begin
         lc_ff  <= lc_in;
         rc_ff  <= rc_in;
         pos_ff <= pos_in;
      end
      src_left_ff <= src_left_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/cle_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing keystrokes and the line flush.
module cle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cle_pkg::sts_type sts,
   output cle_pkg::cmd_type cmd
);
   import cle_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MV_L,
      S_MV_R,
      S_FL_RD,
      S_FL_LOAD,
      S_FL_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func) begin
                  if (sts.empty) begin
                     cmd.op   = OP_FL_EMPTY;
                     state_in = S_FL_WAIT;
                  end else begin
                     state_in = S_FL_RD;
                  end
               end else begin
                  unique case (sts.key_cls)
                     KEY_LEFT: begin
                        if (sts.can_left) begin
                           cmd.op   = OP_MVL_RD;
                           state_in = S_MV_L;
                        end
                     end
                     KEY_RIGHT: begin
                        if (sts.can_right) begin
                           cmd.op   = OP_MVR_RD;
                           state_in = S_MV_R;
                        end
                     end
                     KEY_ERASE: begin
                        if (sts.can_erase) begin
                           cmd.op = OP_ERASE;
                        end
                     end
                     KEY_CHAR: begin
                        // drop the character when the line is full
                        if (sts.can_insert) begin
                           cmd.op = OP_INSERT;
                        end
                     end
                     default: cmd.op = OP_NONE;
                  endcase
               end
            end
         end
         S_MV_L: begin
            cmd.op   = OP_MVL_WR;
            state_in = S_IDLE;
         end
         S_MV_R: begin
            cmd.op   = OP_MVR_WR;
            state_in = S_IDLE;
         end
         S_FL_RD: begin
            cmd.op   = OP_FL_RD;
            state_in = S_FL_LOAD;
         end
         S_FL_LOAD: begin
            cmd.op   = OP_FL_LOAD;
            state_in = S_FL_WAIT;
         end
         S_FL_WAIT: begin
            if (rsp_ready) begin
               if (sts.last) begin
                  cmd.op   = OP_CLEAR;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FL_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
         valid_ff <= (state_in == S_FL_WAIT);
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

>>> sv/cursor_line_edit_buffer.sv
`timescale 1ns / 1ps
// Top level of the cursor line edit buffer.
// Line editor that keeps a line of up to LINE_DEPTH characters as a gap buffer: one
// RAM stack for the characters left of the cursor and one for those right of it.
// A keystroke request that inserts, erases or is ignored completes in the idle state;
// a cursor move also passes a write state, since the moved character is read from one
// stack's RAM (registered read) and written into the other in the next cycle. A flush
// request emits the line in order, each character going through a RAM read, a result
// load and a result handshake that waits while rsp_ready stays low, and no request is
// taken until the last character is delivered and the buffer cleared. An empty line
// flushes as one result with line_empty set. The key codes for left, right and erase
// live in registers at byte addresses 0, 4 and 8 and reset to '<', '>' and '-'.
module cursor_line_edit_buffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cle_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cle_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import cle_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   cle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cle_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

endmodule

>>> sv/cle_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the cursor line edit buffer, bound to the top level.
module cle_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input cle_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cle_pkg::rsp_type rsp_data
);
   import cle_pkg::*;

   // a result waiting for its taker holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // no request is taken while a flushed character is on offer
   a_no_req_during_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request port open during flush output");

   // an accepted flush request stalls the input on the next cycle
   a_flush_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.func |=> !req_ready)
      else $error("input not stalled after flush request");

   // an empty-line result is always the only and last one
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_empty |-> rsp_data.is_last && (rsp_data.out_char == 8'd0))
      else $error("empty-line result without last mark");

endmodule

bind cursor_line_edit_buffer cle_checker u_checker (.*);

>>> tb/cursor_line_edit_buffer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cursor line edit buffer: keystroke and flush requests.
module cursor_line_edit_buffer_test;
   import cle_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   // Keeps its own copy of the gap buffer and the queue of characters a flush must give.
   class line_scoreboard;
      logic [7:0] left_chars [LINE_DEPTH];
      logic [7:0] right_chars [LINE_DEPTH];
      int         left_n;
      int         right_n;
      cfg_type    codes;
      rsp_type    chars_due [$];
      int         errors;

      function new();
         left_n = 0;
         right_n = 0;
         codes.left_code = LEFT_CODE_RST;
         codes.right_code = RIGHT_CODE_RST;
         codes.erase_code = ERASE_CODE_RST;
         errors = 0;
      endfunction

      function void set_code(input reg_idx_type idx, input logic [7:0] value);
         case (idx)
            REG_LEFT_CODE: codes.left_code = value;
            REG_RIGHT_CODE: codes.right_code = value;
            REG_ERASE_CODE: codes.erase_code = value;
            default: ;
         endcase
      endfunction

      function void apply_request(input req_type item);
         rsp_type r;
         int      i;
         int      k;
         int      total;
         if (!item.func) begin
            if (item.key == codes.left_code) begin
               if (left_n > 0 && right_n < LINE_DEPTH) begin
                  left_n--;
                  right_chars[right_n] = left_chars[left_n];
                  right_n++;
               end
            end else if (item.key == codes.right_code) begin
               if (right_n > 0 && left_n < LINE_DEPTH) begin
                  right_n--;
                  left_chars[left_n] = right_chars[right_n];
                  left_n++;
               end
            end else if (item.key == codes.erase_code) begin
               if (left_n > 0) left_n--;
            end else if (left_n + right_n < LINE_DEPTH) begin
               left_chars[left_n] = item.key;
               left_n++;
            end
            return;
         end
         total = left_n + right_n;
         if (total == 0) begin
            r.out_char = 8'h00;
            r.is_last = 1'b1;
            r.line_empty = 1'b1;
            chars_due.push_back(r);
         end else begin
            k = 0;
            for (i = 0; i < left_n; i++) begin
               r.out_char = left_chars[i];
               r.is_last = (k == total - 1);
               r.line_empty = 1'b0;
               chars_due.push_back(r);
               k++;
            end
            for (i = right_n - 1; i >= 0; i--) begin
               r.out_char = right_chars[i];
               r.is_last = (k == total - 1);
               r.line_empty = 1'b0;
               chars_due.push_back(r);
               k++;
            end
         end
         left_n = 0;
         right_n = 0;
      endfunction

      function void check_char(input rsp_type got);
         rsp_type want;
         if (chars_due.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected result: expected none, got char %02h last %b empty %b",
                        $time, got.out_char, got.is_last, got.line_empty);
            return;
         end
         want = chars_due.pop_front();
         if (got.out_char !== want.out_char || got.is_last !== want.is_last ||
             got.line_empty !== want.line_empty) begin
            errors++;
            if (errors <= 40)
               $display("%0t: expected %02h last %b empty %b, got %02h last %b empty %b",
                        $time, want.out_char, want.is_last, want.line_empty,
                        got.out_char, got.is_last, got.line_empty);
         end
      endfunction

      function int pending();
         return chars_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   line_scoreboard book = new();
   bit             no_idling = 1'b0;
   int             requests_sent = 0;
   int             idle_cycles = 0;
   int             stall_left = 0;

   cursor_line_edit_buffer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Stall the result side in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (!no_idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      rsp_ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_char(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Call right after a rising edge; valid stays high into the next request when there is no gap.
   task automatic send_request(input req_type item);
      if (!no_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      book.apply_request(item);
      requests_sent++;
   endtask

   task automatic send_key(input logic [7:0] key);
      req_type item;
      item.func = 1'b0;
      item.key = key;
      send_request(item);
   endtask

   task automatic send_flush();
      req_type item;
      item.func = 1'b1;
      item.key = 8'($urandom_range(0, 255));
      send_request(item);
   endtask

   // Drain all results, then give the block time to finish any cursor move.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_codes(input cfg_type c);
      reg_idx_type order [3];
      logic [7:0]  vals [3];
      int          n;
      order = '{REG_LEFT_CODE, REG_RIGHT_CODE, REG_ERASE_CODE};
      vals = '{c.left_code, c.right_code, c.erase_code};
      for (n = 0; n < 3; n++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {order[n], 2'b00};
         csr_pwdata <= CSR_DATA_W'(vals[n]);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         book.set_code(order[n], vals[n]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] pick_key(input int insert_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) return 8'($urandom_range(0, 255));
      case (roll % 3)
         0: return book.codes.left_code;
         1: return book.codes.right_code;
         default: return book.codes.erase_code;
      endcase
   endfunction

   task automatic run_phase(input cfg_type c, input int budget, input bit long_line);
      int start;
      int line_no;
      int len;
      int n;
      int roll;
      req_type item;
      settle();
      write_codes(c);
      start = requests_sent;
      line_no = 0;
      while (requests_sent - start < budget) begin
         roll = $urandom_range(0, 9);
         if (long_line && line_no == 1) begin
            // long line to hit the full-buffer drop
            len = $urandom_range(72, 90);
            for (n = 0; n < len; n++) send_key(pick_key(92));
            send_flush();
         end else if (roll < 2) begin
            len = $urandom_range(1, 8);
            for (n = 0; n < len; n++) begin
               item.func = ($urandom_range(0, 5) == 0);
               item.key = 8'($urandom_range(0, 255));
               send_request(item);
            end
         end else begin
            len = $urandom_range(0, 12);
            for (n = 0; n < len; n++) send_key(pick_key(55));
            send_flush();
         end
         line_no++;
      end
   endtask

   initial begin
      cfg_type settings [7];
      int      p;
      settings[0] = '{left_code: 8'd0, right_code: 8'd255, erase_code: 8'd128};
      settings[1] = '{left_code: 8'd255, right_code: 8'd0, erase_code: 8'd1};
      settings[2] = '{left_code: 8'd7, right_code: 8'd7, erase_code: 8'd7};
      settings[3] = '{left_code: 8'd10, right_code: 8'd20, erase_code: 8'd20};
      settings[4] = '{left_code: 8'd30, right_code: 8'd31, erase_code: 8'd30};
      settings[5].left_code = 8'($urandom_range(0, 255));
      settings[5].right_code = 8'($urandom_range(0, 255));
      settings[5].erase_code = 8'($urandom_range(0, 255));
      settings[6] = '{left_code: LEFT_CODE_RST, right_code: RIGHT_CODE_RST,
                      erase_code: ERASE_CODE_RST};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset codes: empty flush, moves and erase at the ends,
      // extreme characters, edits in the middle of the line, flush with a stray key.
      send_flush();
      send_key(LEFT_CODE_RST);
      send_key(RIGHT_CODE_RST);
      send_key(ERASE_CODE_RST);
      send_key(8'h00);
      send_key(8'hFF);
      send_key(8'h55);
      send_key(8'hAA);
      send_key(LEFT_CODE_RST);
      send_key(LEFT_CODE_RST);
      send_key(8'h78);
      send_key(RIGHT_CODE_RST);
      send_key(ERASE_CODE_RST);
      send_key(RIGHT_CODE_RST);
      send_key(RIGHT_CODE_RST);
      repeat (5) send_key(LEFT_CODE_RST);
      send_key(8'h79);
      send_flush();
      send_flush();

      for (p = 0; p < 7; p++) begin
         if (p == 6) no_idling = 1'b1;
         run_phase(settings[p], 30, p == 6);
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
